### sv/led_matrix_scan_serializer_defines.svh
// Assertion macros shared by the LED matrix scan serializer RTL.
`ifndef LED_MATRIX_SCAN_SERIALIZER_DEFINES_SVH
`define LED_MATRIX_SCAN_SERIALIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LMSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LMSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LMSS_ASSERT_RST(lbl, prop, msg)
`define LMSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/lmss_pkg.sv
// Types and constants of the LED matrix scan serializer.
`default_nettype none
package lmss_pkg;

  localparam int unsigned Columns = 12;
  localparam int unsigned WordBits = 24;
  localparam int unsigned CathBits = 8;
  localparam logic [15:0] DwellReset = 16'd50;
  localparam logic [3:0] ActiveReset = 4'd12;

  typedef enum logic [1:0] {
    PH_START,
    PH_SHIFT,
    PH_SHOW
  } phase_e;

  typedef enum logic {
    CMD_TICK,
    CMD_WRITE
  } cmd_e;

  typedef enum logic {
    CFG_DWELL,
    CFG_ACTIVE
  } cfg_idx_e;

  typedef struct packed {
    logic cathode_data;
    logic cathode_clock;
    logic anode_data;
    logic anode_clock;
    logic latch;
  } pins_t;

  typedef struct packed {
    logic [15:0] dwell_ticks;
    logic [3:0]  active_columns;
  } cfg_t;

endpackage
`default_nettype wire

### sv/led_matrix_scan_serializer.sv
// Top level of the LED matrix scan serializer.
// The block takes one transaction per clock cycle. A tick transaction yields
// one pin-state transaction, registered in the cycle after it; a write transaction
// updates the frame store and yields none. The rate is set by the scan
// sequencer, whose next state is formed combinationally from its registers and
// inputs, and by the output register, which is loaded while its previous
// transaction is being taken, so the input stalls only while the output stalls.
// Each column takes one start tick, 48 shift ticks and dwell_ticks show ticks (one if zero).
`default_nettype none
`include "led_matrix_scan_serializer_defines.svh"
module led_matrix_scan_serializer #(
  parameter int unsigned Columns = lmss_pkg::Columns
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: column [3:0], pattern [11:4], zero [15:12]
  input  wire logic [15:0] s_axis_tdata_i,
  // tuser: command
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: latch, anode_clock, anode_data, cathode_clock, cathode_data,
  // column_now [8:5], zero [15:9]
  output logic      [15:0] m_axis_tdata_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  lmss_pkg::cfg_t  cfg_q;
  lmss_pkg::pins_t pins;
  logic [3:0] col_now;
  logic [3:0] rd_col;
  logic [7:0] rd_data;
  logic       s_fire;
  logic       is_write;
  logic       tick;
  logic       out_valid_q;
  logic [15:0] out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign is_write = lmss_pkg::cmd_e'(s_axis_tuser_i) == lmss_pkg::CMD_WRITE;
  assign tick = s_fire && !is_write;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dwell_ticks <= lmss_pkg::DwellReset;
      cfg_q.active_columns <= lmss_pkg::ActiveReset;
    end else if (cfg_we_i) begin
      case (lmss_pkg::cfg_idx_e'(cfg_index_i))
        lmss_pkg::CFG_DWELL: begin
          cfg_q.dwell_ticks <= cfg_data_i;
        end
        lmss_pkg::CFG_ACTIVE: begin
          cfg_q.active_columns <= cfg_data_i[3:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  lmss_frame_store #(
    .Columns(Columns)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (s_fire && is_write),
    .wr_col_i (s_axis_tdata_i[3:0]),
    .wr_data_i(s_axis_tdata_i[11:4]),
    .rd_col_i (rd_col),
    .rd_data_o(rd_data)
  );

  lmss_scan_core #(
    .Columns(Columns)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .cfg_i    (cfg_q),
    .rd_data_i(rd_data),
    .rd_col_o (rd_col),
    .pins_o   (pins),
    .col_now_o(col_now)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_data_q <= {7'd0, col_now, pins};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;

  `LMSS_ASSERT_RST(a_tick_gives_result, tick |=> m_axis_tvalid_o, "tick transaction lost")
  `LMSS_ASSERT_RST(a_write_no_result, (s_fire && is_write) |=> !m_axis_tvalid_o, "write made a result")
  `LMSS_ASSERT_RST(a_latch_clocks_low, (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (!m_axis_tdata_o[1] && !m_axis_tdata_o[3]), "clock high while latched")
  `LMSS_ASSERT_ALWAYS(a_one_clock, m_axis_tvalid_o |-> !(m_axis_tdata_o[1] && m_axis_tdata_o[3]), "both shift clocks high")

endmodule
`default_nettype wire

### sv/lmss_frame_store.sv
// Frame store: one row pattern per column, cleared at reset.
`default_nettype none
module lmss_frame_store #(
  parameter int unsigned Columns = lmss_pkg::Columns
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_en_i,
  input  wire logic [3:0] wr_col_i,
  input  wire logic [7:0] wr_data_i,
  input  wire logic [3:0] rd_col_i,
  output logic      [7:0] rd_data_o
);

  localparam int unsigned IdxW = (Columns > 1) ? $clog2(Columns) : 1;
  localparam logic [4:0] ColLimit = 5'(Columns);

  logic [7:0] store_q [Columns];
  logic       wr_ok;
  logic       rd_ok;

  assign wr_ok = {1'b0, wr_col_i} < ColLimit;
  assign rd_ok = {1'b0, rd_col_i} < ColLimit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Columns; i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_en_i && wr_ok) begin
      store_q[wr_col_i[IdxW-1:0]] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_ok ? store_q[rd_col_i[IdxW-1:0]] : store_q[0];

endmodule
`default_nettype wire

### sv/lmss_scan_core.sv
// Scan sequencer: phase, bit and dwell counters and the pin levels.
`default_nettype none
module lmss_scan_core #(
  parameter int unsigned Columns = lmss_pkg::Columns
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tick_i,
  input  wire lmss_pkg::cfg_t cfg_i,
  input  wire logic    [7:0] rd_data_i,
  output logic         [3:0] rd_col_o,
  output lmss_pkg::pins_t    pins_o,
  output logic         [3:0] col_now_o
);

  localparam logic [4:0] ColLimit = 5'(Columns);
  localparam logic [4:0] LastBit = 5'(lmss_pkg::WordBits - 1);
  localparam logic [4:0] CathLimit = 5'(lmss_pkg::CathBits);

  lmss_pkg::phase_e phase_q, phase_d;
  logic [3:0]  col_q, col_d;
  logic [4:0]  bit_q, bit_d;
  logic        half_q, half_d;
  logic [15:0] dwell_q, dwell_d;
  logic [23:0] word_q, word_d;
  lmss_pkg::pins_t pins_q, pins_d;

  logic        cur_bit;
  logic        cath;
  logic [15:0] cnt;
  logic [15:0] dwell_lim;
  logic [3:0]  act_lim;
  logic [4:0]  next_col;
  logic [15:0] onehot;

  always_comb begin
    phase_d = phase_q;
    col_d = col_q;
    bit_d = bit_q;
    half_d = half_q;
    dwell_d = dwell_q;
    word_d = word_q;
    pins_d = pins_q;
    cur_bit = word_q[LastBit - bit_q];
    cath = bit_q < CathLimit;
    cnt = dwell_q + 16'd1;
    dwell_lim = (cfg_i.dwell_ticks == '0) ? 16'd1 : cfg_i.dwell_ticks;
    act_lim = (cfg_i.active_columns == '0) ? 4'd1 : cfg_i.active_columns;
    next_col = {1'b0, col_q} + 5'd1;
    onehot = '0;
    onehot[col_q] = 1'b1;
    case (phase_q)
      lmss_pkg::PH_SHIFT: begin
        pins_d.latch = 1'b0;
        pins_d.anode_clock = 1'b0;
        pins_d.cathode_clock = 1'b0;
        if (cath) begin
          pins_d.cathode_data = cur_bit;
        end else begin
          pins_d.anode_data = cur_bit;
        end
        if (half_q) begin
          if (cath) begin
            pins_d.cathode_clock = 1'b1;
          end else begin
            pins_d.anode_clock = 1'b1;
          end
          half_d = 1'b0;
          if (bit_q == LastBit) begin
            bit_d = '0;
            dwell_d = '0;
            phase_d = lmss_pkg::PH_SHOW;
          end else begin
            bit_d = bit_q + 5'd1;
          end
        end else begin
          half_d = 1'b1;
        end
      end
      lmss_pkg::PH_SHOW: begin
        pins_d.anode_clock = 1'b0;
        pins_d.cathode_clock = 1'b0;
        pins_d.latch = 1'b1;
        if (cnt >= dwell_lim) begin
          dwell_d = '0;
          phase_d = lmss_pkg::PH_START;
          if (next_col >= {1'b0, act_lim} || next_col >= ColLimit) begin
            col_d = '0;
          end else begin
            col_d = next_col[3:0];
          end
        end else begin
          dwell_d = cnt;
        end
      end
      default: begin
        word_d = {~rd_data_i, onehot};
        pins_d.latch = 1'b0;
        pins_d.anode_clock = 1'b0;
        pins_d.cathode_clock = 1'b0;
        bit_d = '0;
        half_d = 1'b0;
        phase_d = lmss_pkg::PH_SHIFT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lmss_pkg::PH_START;
      col_q <= '0;
      bit_q <= '0;
      half_q <= 1'b0;
      dwell_q <= '0;
      word_q <= '0;
      pins_q <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
      col_q <= col_d;
      bit_q <= bit_d;
      half_q <= half_d;
      dwell_q <= dwell_d;
      word_q <= word_d;
      pins_q <= pins_d;
    end
  end

  assign rd_col_o = col_q;
  assign pins_o = pins_d;
  assign col_now_o = col_q;

endmodule
`default_nettype wire

### bench/lmss_scan_checker.sv
// Scoreboard for the LED matrix scan serializer: predicts and checks every pin state.
module lmss_scan_checker
  import lmss_pkg::*;
#(
  parameter int unsigned Columns = lmss_pkg::Columns
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic       [15:0] s_axis_tdata_i,
  input  logic              s_axis_tuser_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic       [15:0] m_axis_tdata_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic       [15:0] cfg_data_i,
  output int unsigned       failures_o,
  output int unsigned       outstanding_o,
  output int unsigned       compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pins_t       pins;
    logic [3:0]  column;
  } pin_state_t;

  string pin_names [5] = '{"latch", "anode_clock", "anode_data", "cathode_clock",
                           "cathode_data"};

  pin_state_t  pending_states[$];
  logic [7:0]  frame_rows[Columns];
  logic [15:0] dwell_reg;
  logic [3:0]  active_reg;
  logic [3:0]  scan_col;
  phase_e      phase;
  int unsigned bit_pos;
  bit          half;
  int unsigned dwell_cnt;
  logic [23:0] shift_word;
  pins_t       pins;

  task automatic report_mismatch(input string msg);
    $display("ERROR: pin state %0d: %s", compared_o, msg);
    failures_o++;
  endtask

  function automatic void clear_scan();
    foreach (frame_rows[i]) frame_rows[i] = 8'h00;
    dwell_reg  = DwellReset;
    active_reg = ActiveReset;
    scan_col   = '0;
    phase      = PH_START;
    bit_pos    = 0;
    half       = 1'b0;
    dwell_cnt  = 0;
    shift_word = '0;
    pins       = '0;
  endfunction

  function automatic pin_state_t scan_tick();
    pin_state_t  r;
    int unsigned bi;
    int unsigned lim;
    int unsigned next_col;
    int unsigned row_idx;
    logic        bit_val;
    r.column = scan_col;
    case (phase)
      PH_SHIFT: begin
        bi = (bit_pos < WordBits) ? bit_pos : WordBits - 1;
        bit_val = shift_word[WordBits - 1 - bi];
        pins.latch = 1'b0;
        pins.anode_clock = 1'b0;
        pins.cathode_clock = 1'b0;
        if (bi < CathBits) pins.cathode_data = bit_val;
        else pins.anode_data = bit_val;
        if (half) begin
          if (bi < CathBits) pins.cathode_clock = 1'b1;
          else pins.anode_clock = 1'b1;
          half = 1'b0;
          bit_pos = bi + 1;
          if (bit_pos >= WordBits) begin
            bit_pos = 0;
            dwell_cnt = 0;
            phase = PH_SHOW;
          end
        end else begin
          half = 1'b1;
        end
      end
      PH_SHOW: begin
        lim = (dwell_reg == 16'd0) ? 1 : dwell_reg;
        pins.anode_clock = 1'b0;
        pins.cathode_clock = 1'b0;
        pins.latch = 1'b1;
        dwell_cnt++;
        if (dwell_cnt >= lim) begin
          dwell_cnt = 0;
          lim = (active_reg == 4'd0) ? 1 : active_reg;
          next_col = scan_col + 1;
          if (next_col >= lim || next_col >= Columns) next_col = 0;
          scan_col = next_col[3:0];
          phase = PH_START;
        end
      end
      default: begin
        row_idx = (scan_col < Columns) ? scan_col : 0;
        shift_word = {~frame_rows[row_idx], 16'(1 << scan_col)};
        pins.latch = 1'b0;
        pins.anode_clock = 1'b0;
        pins.cathode_clock = 1'b0;
        bit_pos = 0;
        half = 1'b0;
        phase = PH_SHIFT;
      end
    endcase
    r.pins = pins;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pin_state_t due;
    if (!rst_ni) begin
      clear_scan();
      pending_states.delete();
      failures_o = 0;
      compared_o = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_DWELL) dwell_reg = cfg_data_i;
        else active_reg = cfg_data_i[3:0];
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_states.size() == 0) begin
          report_mismatch("transaction arrived with nothing expected");
        end else begin
          due = pending_states.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (m_axis_tdata_i[i] !== due.pins[i])
              report_mismatch($sformatf("%s expected %0b, got %0b", pin_names[i],
                                        due.pins[i], m_axis_tdata_i[i]));
          end
          if (m_axis_tdata_i[8:5] !== due.column)
            report_mismatch($sformatf("column_now expected %0d, got %0d", due.column,
                                      m_axis_tdata_i[8:5]));
        end
        compared_o++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (cmd_e'(s_axis_tuser_i) == CMD_WRITE) begin
          if (s_axis_tdata_i[3:0] < Columns)
            frame_rows[s_axis_tdata_i[3:0]] = s_axis_tdata_i[11:4];
        end else begin
          pending_states.push_back(scan_tick());
        end
      end
      outstanding_o <= pending_states.size();
    end
  end

endmodule

### bench/tb.sv
// Top of the LED matrix scan serializer testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lmss_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  cmd_e        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we;
  cfg_idx_e    cfg_index;
  logic [15:0] cfg_data;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned compared;
  int unsigned tick_count;
  int unsigned write_count;
  int unsigned setting_count;
  int unsigned cycle_count;
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_request;

  led_matrix_scan_serializer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  lmss_scan_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .failures_o      (failures),
    .outstanding_o   (outstanding),
    .compared_o      (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out with %0d pin states still expected.", outstanding);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : sink
    int unsigned held;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk_i);
          held++;
        end
        m_axis_tready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [3:0] col, input logic [7:0] pat);
    if (src_gaps && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0000, pat, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == CMD_TICK) tick_count++;
    else write_count++;
  endtask

  task automatic random_item();
    logic [3:0]  col;
    logic [7:0]  pat;
    int unsigned pick;
    col = 4'($urandom_range(0, 15));
    pat = 8'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) pat = 8'h00;
    else if (pick == 1) pat = 8'hFF;
    send_item(($urandom_range(0, 99) < 85) ? CMD_TICK : CMD_WRITE, col, pat);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] dwell, input logic [3:0] active,
                           input int unsigned count, input bit hold);
    settle();
    write_reg(CFG_DWELL, dwell);
    write_reg(CFG_ACTIVE, {12'd0, active});
    cfg_we <= 1'b0;
    setting_count++;
    if (hold) hold_request = 1'b1;
    repeat (count) random_item();
  endtask

  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_TICK;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DWELL;
    cfg_data <= '0;
    rst_ni <= 1'b0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_request = 1'b0;
    tick_count = 0;
    write_count = 0;
    setting_count = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_WRITE, 4'd0, 8'hFF);
    send_item(CMD_WRITE, 4'd11, 8'h01);
    send_item(CMD_WRITE, 4'd1, 8'h80);
    send_item(CMD_WRITE, 4'd12, 8'hFF);
    send_item(CMD_WRITE, 4'd15, 8'h5A);
    send_item(CMD_WRITE, 4'd2, 8'h00);
    repeat (5) send_item(CMD_TICK, 4'hF, 8'hFF);
    send_item(CMD_WRITE, 4'd0, 8'h00);
    repeat (13) send_item(CMD_TICK, 4'h0, 8'h00);

    run_phase(16'd1, 4'd12, 300, 1'b0);
    run_phase(16'd2, 4'd15, 350, 1'b1);
    run_phase(16'd0, 4'd0, 120, 1'b0);
    run_phase(16'd3, 4'd4, 200, 1'b0);
    run_phase(16'hFFFF, 4'd1, 80, 1'b0);
    run_phase(16'd1, 4'd1, 100, 1'b0);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    run_phase(16'd50, 4'd12, 150, 1'b0);
    settle();
    repeat (8) @(posedge clk_i);

    $display("Drove %0d tick and %0d write transactions under %0d register settings.",
             tick_count, write_count, setting_count);
    $display("Checked %0d pin states, with dwell from 0 to 65535 and a %0d-cycle hold-off.",
             compared, HoldCycles);
    if (failures == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
